/* hdl/htok_pkg.sv */
// Package with the shared types, codes and helper functions of the HTTP request tokenizer.
`default_nettype none

package htok_pkg;

  // Default depth of the queue between the parser and the output stage.
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Characters the parser reacts to.
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Token kinds carried in token_kind.
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_METHOD  = 3'd1;
  localparam logic [2:0] KIND_TARGET  = 3'd2;
  localparam logic [2:0] KIND_VERSION = 3'd3;
  localparam logic [2:0] KIND_HNAME   = 3'd4;
  localparam logic [2:0] KIND_HVALUE  = 3'd5;
  localparam logic [2:0] KIND_IGNORED = 3'd6;

  // Method codes carried in method_code.
  localparam logic [2:0] MCODE_UNKNOWN = 3'd0;
  localparam logic [2:0] MCODE_GET     = 3'd1;
  localparam logic [2:0] MCODE_POST    = 3'd2;
  localparam logic [2:0] MCODE_HEAD    = 3'd3;
  localparam logic [2:0] MCODE_PUT     = 3'd4;

  // Parts of the request line.
  localparam logic [1:0] PART_METHOD  = 2'd0;
  localparam logic [1:0] PART_IGNORED = 2'd3;

  // Method names, one row per candidate (GET, POST, HEAD, PUT), and their lengths.
  localparam logic [7:0] METHOD_CHARS [4][4] = '{
    '{"G", "E", "T", 8'h00},
    '{"P", "O", "S", "T"},
    '{"H", "E", "A", "D"},
    '{"P", "U", "T", 8'h00}
  };
  localparam logic [2:0] METHOD_LENS [4] = '{3'd3, 3'd4, 3'd4, 3'd3};
  localparam logic [2:0] METHOD_CODES [4] = '{MCODE_GET, MCODE_POST, MCODE_HEAD, MCODE_PUT};

  typedef enum logic [1:0] {
    PH_REQ   = 2'd0,
    PH_NAME  = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] data_in;
    logic       new_request;
  } htok_in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic [2:0] token_kind;
    logic       token_end;
    logic       line_end;
    logic       request_done;
    logic [2:0] method_code;
    logic       last;
  } htok_out_t;

  // One queue entry holds all results of one input beat: one or two.
  typedef struct packed {
    logic      two;
    htok_out_t res0;
    htok_out_t res1;
  } htok_entry_t;

  // Queue status seen by the parser and the output stage.
  typedef struct packed {
    logic full;
    logic empty;
  } htok_qstat_t;

  // Parser state.
  typedef struct packed {
    phase_e     phase;
    logic [1:0] part;
    logic       cr;
    logic       skip;
    logic [3:0] cand;
    logic [2:0] pos;
  } htok_pstate_t;

  localparam htok_pstate_t PSTATE_RESET = '{
    phase: PH_REQ, part: PART_METHOD, cr: 1'b0, skip: 1'b0, cand: 4'hf, pos: 3'd0
  };

  typedef struct packed {
    logic [3:0] cand;
    logic [2:0] pos;
  } htok_mstate_t;

  // Drops the candidates whose letter at the current position does not match.
  function automatic htok_mstate_t method_upd(logic [3:0] cand, logic [2:0] pos,
                                              logic [7:0] b);
    htok_mstate_t r;
    r.cand = cand;
    for (int i = 0; i < 4; i++) begin
      if (cand[i] && (pos < METHOD_LENS[i]) && (b != METHOD_CHARS[i][pos[1:0]])) begin
        r.cand[i] = 1'b0;
      end
    end
    r.pos = (pos == 3'd7) ? pos : pos + 3'd1;
    return r;
  endfunction

  // First candidate that is still alive and has matched all of its letters.
  function automatic logic [2:0] method_code(logic [3:0] cand, logic [2:0] pos);
    logic [2:0] code;
    code = MCODE_UNKNOWN;
    for (int i = 3; i >= 0; i--) begin
      if (cand[i] && (pos >= METHOD_LENS[i])) begin
        code = METHOD_CODES[i];
      end
    end
    return code;
  endfunction

  function automatic htok_out_t mk_res(logic [7:0] b, logic [2:0] kind, logic tend,
                                       logic lend, logic done, logic [2:0] mcode);
    htok_out_t r;
    r.data_out     = b;
    r.token_kind   = kind;
    r.token_end    = tend;
    r.line_end     = lend;
    r.request_done = done;
    r.method_code  = mcode;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/htok_front.sv */
// Parser front end: accepts request bytes, tracks the parse state and builds queue entries.
`default_nettype none

module htok_front
  import htok_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  htok_in_t    in_data_i,
  input  htok_qstat_t qstat_i,
  output logic        push_o,
  output htok_entry_t entry_o
);

  htok_pstate_t st_q, st_d;
  htok_pstate_t s;
  htok_mstate_t mu;
  htok_out_t    pre, x;
  logic         pre_valid, x_valid;
  logic [7:0]   b;
  logic         accept;

  function automatic logic [2:0] data_kind(phase_e ph, logic [1:0] part);
    logic [2:0] k;
    unique case (ph)
      PH_REQ: begin
        if (part == PART_METHOD) begin
          k = KIND_METHOD;
        end else if (part == PART_IGNORED) begin
          k = KIND_IGNORED;
        end else begin
          k = {1'b0, part} + 3'd1;
        end
      end
      PH_NAME: k = KIND_HNAME;
      default: k = KIND_HVALUE;
    endcase
    return k;
  endfunction

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_data_i.data_in;

  always_comb begin
    s         = in_data_i.new_request ? PSTATE_RESET : st_q;
    st_d      = s;
    pre       = '0;
    x         = '0;
    pre_valid = 1'b0;
    x_valid   = 1'b0;
    mu        = '0;

    if (s.phase == PH_DONE) begin
      x_valid = 1'b1;
      x       = mk_res(b, KIND_IGNORED, 1'b0, 1'b0, 1'b0, MCODE_UNKNOWN);
    end else if (s.cr && (b == CH_LF)) begin
      st_d.cr   = 1'b0;
      pre_valid = 1'b1;
      pre       = mk_res(CH_CR, KIND_NONE, 1'b0, 1'b0, 1'b0, MCODE_UNKNOWN);
      x_valid   = 1'b1;
      unique case (s.phase)
        PH_REQ: begin
          if (s.part == PART_IGNORED) begin
            x = mk_res(CH_LF, KIND_IGNORED, 1'b0, 1'b1, 1'b0, MCODE_UNKNOWN);
          end else begin
            x = mk_res(CH_LF, {1'b0, s.part} + 3'd1, 1'b1, 1'b1, 1'b0,
                       (s.part == PART_METHOD) ? method_code(s.cand, s.pos)
                                               : MCODE_UNKNOWN);
          end
          st_d.phase = PH_NAME;
        end
        PH_NAME: begin
          x          = mk_res(CH_LF, KIND_NONE, 1'b0, 1'b1, 1'b1, MCODE_UNKNOWN);
          st_d.phase = PH_DONE;
        end
        default: begin
          x          = mk_res(CH_LF, KIND_HVALUE, 1'b1, 1'b1, 1'b0, MCODE_UNKNOWN);
          st_d.phase = PH_NAME;
        end
      endcase
    end else begin
      // A held CR that is not followed by LF turns into ordinary token data.
      if (s.cr) begin
        st_d.cr   = 1'b0;
        pre_valid = 1'b1;
        pre       = mk_res(CH_CR, data_kind(s.phase, s.part), 1'b0, 1'b0, 1'b0,
                           MCODE_UNKNOWN);
        if ((s.phase == PH_REQ) && (s.part == PART_METHOD)) begin
          mu        = method_upd(s.cand, s.pos, CH_CR);
          st_d.cand = mu.cand;
          st_d.pos  = mu.pos;
        end
      end
      priority if ((s.phase == PH_VALUE) && s.skip) begin
        st_d.skip = 1'b0;
        x_valid   = 1'b1;
        x         = mk_res(b, KIND_IGNORED, 1'b0, 1'b0, 1'b0, MCODE_UNKNOWN);
      end else if (b == CH_CR) begin
        st_d.cr = 1'b1;
      end else if ((s.phase == PH_REQ) && (b == CH_SPACE)) begin
        x_valid = 1'b1;
        if (s.part == PART_IGNORED) begin
          x = mk_res(b, KIND_IGNORED, 1'b0, 1'b0, 1'b0, MCODE_UNKNOWN);
        end else begin
          x = mk_res(b, {1'b0, s.part} + 3'd1, 1'b1, 1'b0, 1'b0,
                     (s.part == PART_METHOD) ? method_code(st_d.cand, st_d.pos)
                                             : MCODE_UNKNOWN);
          st_d.part = s.part + 2'd1;
        end
      end else if ((s.phase == PH_NAME) && (b == CH_COLON)) begin
        x_valid    = 1'b1;
        x          = mk_res(b, KIND_HNAME, 1'b1, 1'b0, 1'b0, MCODE_UNKNOWN);
        st_d.phase = PH_VALUE;
        st_d.skip  = 1'b1;
      end else begin
        x_valid = 1'b1;
        x       = mk_res(b, data_kind(s.phase, s.part), 1'b0, 1'b0, 1'b0, MCODE_UNKNOWN);
        if ((s.phase == PH_REQ) && (s.part == PART_METHOD)) begin
          mu        = method_upd(st_d.cand, st_d.pos, b);
          st_d.cand = mu.cand;
          st_d.pos  = mu.pos;
        end
      end
    end
  end

  always_comb begin
    entry_o = '0;
    if (pre_valid) begin
      entry_o.res0 = pre;
      entry_o.res1 = x;
      entry_o.two  = x_valid;
    end else begin
      entry_o.res0 = x;
    end
    if (entry_o.two) begin
      entry_o.res1.last = 1'b1;
    end else begin
      entry_o.res0.last = 1'b1;
    end
  end

  assign push_o = accept && (pre_valid || x_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= PSTATE_RESET;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/htok_queue.sv */
// Small entry queue that decouples the parser from the output stage.
`default_nettype none

module htok_queue
  import htok_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         push_i,
  input  htok_entry_t entry_i,
  input  wire         pop_i,
  output htok_entry_t head_o,
  output htok_qstat_t qstat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  htok_entry_t      mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign qstat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign head_o        = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ptr_inc(wptr_q) : wptr_q;
    rptr_d = pop_i ? ptr_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/htok_back.sv */
// Output stage: takes queue entries and presents their results one beat at a time.
`default_nettype none

module htok_back
  import htok_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  htok_entry_t head_i,
  input  htok_qstat_t qstat_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output htok_out_t   out_data_o
);

  htok_entry_t ent_q, ent_d;
  logic        valid_q, valid_d;
  logic        sel_q, sel_d;
  logic        take;

  assign take = valid_q && out_ready_i;

  always_comb begin
    ent_d   = ent_q;
    valid_d = valid_q;
    sel_d   = sel_q;
    pop_o   = 1'b0;
    if (take && !sel_q && ent_q.two) begin
      sel_d = 1'b1;
    end else if (!valid_q || take) begin
      // The current entry is finished: load the next one if there is one.
      sel_d = 1'b0;
      if (!qstat_i.empty) begin
        pop_o   = 1'b1;
        ent_d   = head_i;
        valid_d = 1'b1;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = sel_q ? ent_q.res1 : ent_q.res0;

endmodule

`default_nettype wire

/* hdl/http_request_tokenizer_top.sv */
// Top level of the HTTP request tokenizer: parser, entry queue and output stage.
`default_nettype none

//  Channel | Direction | Handshake                  | Beat payload
//  in      | input     | in_valid_i / in_ready_o    | htok_in_t  (data_in, new_request)
//  out     | output    | out_valid_o / out_ready_i  | htok_out_t (one tagged byte)
//
// The parser takes one byte per clock while the queue has room; every beat that
// yields results writes one queue entry holding one or two results.
// The output stage registers the head entry and sends one result per clock while
// out_ready_i is high, so a two-result entry (CR LF, or a held CR and a non-CR byte)
// occupies it for both results; a held CR alone writes nothing. Input stalls only
// while the queue of QUEUE_DEPTH entries is full. Reset clears the parse state, queue
// pointers and output valid; the block can take a byte in the first cycle after reset.

module http_request_tokenizer_top
  import htok_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  htok_in_t  in_data_i,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  output htok_out_t out_data_o
);

  logic        q_push;
  logic        q_pop;
  htok_entry_t q_entry;
  htok_entry_t q_head;
  htok_qstat_t q_stat;

  // Front: classifies each byte and updates the request parse state.
  htok_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .qstat_i    (q_stat),
    .push_o     (q_push),
    .entry_o    (q_entry)
  );

  // Queue: lets the parser run ahead while the output side is stalled.
  htok_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .qstat_o (q_stat)
  );

  // Back: unpacks entries into single result beats.
  htok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .qstat_i     (q_stat),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // The parser never writes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_stat.full)
    else $error("entry written into a full queue");

  // The output stage never takes an entry from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_stat.empty)
    else $error("entry taken from an empty queue");

  // The end of a request is always a line end and the final result of its beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.request_done) |->
      (out_data_o.line_end && out_data_o.last))
    else $error("request end without line end or last");

  // A method code only appears where a method token closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.method_code != MCODE_UNKNOWN)) |->
      (out_data_o.token_end && (out_data_o.token_kind == KIND_METHOD)))
    else $error("method code outside a method token end");

endmodule

`default_nettype wire

/* test/http_request_tokenizer_top_tb.sv */
// Self-checking testbench for the HTTP request tokenizer: directed and random requests.
module http_request_tokenizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import htok_pkg::*;

  // Request line parts that the package does not name.
  localparam logic [1:0] PART_TARGET  = 2'd1;
  localparam logic [1:0] PART_VERSION = 2'd2;

  // Method spellings used by the prefix matcher, one row per candidate.
  localparam logic [7:0] VERB_CHAR [4][4] = '{
    '{"G", "E", "T", 8'h00},
    '{"P", "O", "S", "T"},
    '{"H", "E", "A", "D"},
    '{"P", "U", "T", 8'h00}
  };
  localparam logic [2:0] VERB_LEN [4]  = '{3'd3, 3'd4, 3'd4, 3'd3};
  localparam logic [2:0] VERB_CODE [4] = '{MCODE_GET, MCODE_POST, MCODE_HEAD, MCODE_PUT};

  string verb_text [4] = '{"GET", "POST", "HEAD", "PUT"};

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  htok_in_t  in_beat  = '0;
  logic      in_ready;
  logic      out_valid;
  logic      out_ready = 1'b0;
  htok_out_t out_data;

  // Tags the parser is expected to produce, oldest first.
  htok_out_t  pending_tags [$];
  // Bytes of the request being assembled before it is sent.
  logic [7:0] req_bytes [$];

  int beats_sent    = 0;
  int mismatches    = 0;
  int receiver_hold = 0;
  bit gaps_on       = 1'b1;
  bit stalls_on     = 1'b1;

  // Shadow of the parser state.
  phase_e     pr_phase;
  logic [1:0] pr_part;
  logic       pr_cr_held;
  logic       pr_skip_next;
  logic [3:0] pr_verbs;
  logic [2:0] pr_verb_pos;

  http_request_tokenizer_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs somewhere the drain loop cannot see.
  initial begin
    #(2_000_000);
    $display("http_request_tokenizer_top verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void parser_clear();
    pr_phase     = PH_REQ;
    pr_part      = PART_METHOD;
    pr_cr_held   = 1'b0;
    pr_skip_next = 1'b0;
    pr_verbs     = 4'hf;
    pr_verb_pos  = 3'd0;
  endfunction

  function automatic void add_tag(logic [7:0] b, logic [2:0] kind, logic tend, logic lend,
                                  logic done, logic [2:0] mcode);
    htok_out_t t;
    t.data_out     = b;
    t.token_kind   = kind;
    t.token_end    = tend;
    t.line_end     = lend;
    t.request_done = done;
    t.method_code  = mcode;
    t.last         = 1'b0;
    pending_tags.push_back(t);
  endfunction

  // A candidate drops out at the first letter that differs; once its whole
  // spelling has matched it stays in, whatever follows.
  function automatic void match_verb(logic [7:0] b);
    for (int i = 0; i < 4; i++) begin
      if (pr_verbs[i] && pr_verb_pos < VERB_LEN[i] && b != VERB_CHAR[i][pr_verb_pos[1:0]]) begin
        pr_verbs[i] = 1'b0;
      end
    end
    if (pr_verb_pos != 3'd7) begin
      pr_verb_pos = pr_verb_pos + 3'd1;
    end
  endfunction

  function automatic logic [2:0] verb_code();
    for (int i = 0; i < 4; i++) begin
      if (pr_verbs[i] && pr_verb_pos >= VERB_LEN[i]) begin
        return VERB_CODE[i];
      end
    end
    return MCODE_UNKNOWN;
  endfunction

  function automatic logic [2:0] line_kind(logic [1:0] p);
    case (p)
      PART_METHOD:  return KIND_METHOD;
      PART_TARGET:  return KIND_TARGET;
      PART_VERSION: return KIND_VERSION;
      default:      return KIND_IGNORED;
    endcase
  endfunction

  function automatic void tag_data(logic [7:0] b);
    logic [2:0] kind;
    case (pr_phase)
      PH_REQ: begin
        if (pr_part == PART_METHOD) begin
          match_verb(b);
        end
        kind = line_kind(pr_part);
      end
      PH_NAME: kind = KIND_HNAME;
      default: kind = KIND_HVALUE;
    endcase
    add_tag(b, kind, 1'b0, 1'b0, 1'b0, MCODE_UNKNOWN);
  endfunction

  // CR LF: the CR goes out untagged; the LF ends the line, closing any token but a name or ignored part.
  function automatic void tag_line_end();
    add_tag(CH_CR, KIND_NONE, 1'b0, 1'b0, 1'b0, MCODE_UNKNOWN);
    case (pr_phase)
      PH_REQ: begin
        if (pr_part == PART_IGNORED) begin
          add_tag(CH_LF, KIND_IGNORED, 1'b0, 1'b1, 1'b0, MCODE_UNKNOWN);
        end else begin
          add_tag(CH_LF, line_kind(pr_part), 1'b1, 1'b1, 1'b0,
                  (pr_part == PART_METHOD) ? verb_code() : MCODE_UNKNOWN);
        end
        pr_phase = PH_NAME;
      end
      PH_NAME: begin
        add_tag(CH_LF, KIND_NONE, 1'b0, 1'b1, 1'b1, MCODE_UNKNOWN);
        pr_phase = PH_DONE;
      end
      default: begin
        add_tag(CH_LF, KIND_HVALUE, 1'b1, 1'b1, 1'b0, MCODE_UNKNOWN);
        pr_phase = PH_NAME;
      end
    endcase
  endfunction

  // Works out the tags that one accepted input beat causes.
  function automatic void tag_request_byte(logic [7:0] b, logic nr);
    int first;
    first = pending_tags.size();
    if (nr) begin
      parser_clear();
    end
    if (pr_phase == PH_DONE) begin
      add_tag(b, KIND_IGNORED, 1'b0, 1'b0, 1'b0, MCODE_UNKNOWN);
    end else if (pr_cr_held && b == CH_LF) begin
      pr_cr_held = 1'b0;
      tag_line_end();
    end else begin
      if (pr_cr_held) begin
        pr_cr_held = 1'b0;
        tag_data(CH_CR);
      end
      if (pr_phase == PH_VALUE && pr_skip_next) begin
        pr_skip_next = 1'b0;
        add_tag(b, KIND_IGNORED, 1'b0, 1'b0, 1'b0, MCODE_UNKNOWN);
      end else if (b == CH_CR) begin
        pr_cr_held = 1'b1;
      end else if (pr_phase == PH_REQ && b == CH_SPACE) begin
        if (pr_part == PART_IGNORED) begin
          add_tag(b, KIND_IGNORED, 1'b0, 1'b0, 1'b0, MCODE_UNKNOWN);
        end else begin
          add_tag(b, line_kind(pr_part), 1'b1, 1'b0, 1'b0,
                  (pr_part == PART_METHOD) ? verb_code() : MCODE_UNKNOWN);
          pr_part = pr_part + 2'd1;
        end
      end else if (pr_phase == PH_NAME && b == CH_COLON) begin
        add_tag(b, KIND_HNAME, 1'b1, 1'b0, 1'b0, MCODE_UNKNOWN);
        pr_phase     = PH_VALUE;
        pr_skip_next = 1'b1;
      end else begin
        tag_data(b);
      end
    end
    if (pending_tags.size() > first) begin
      pending_tags[pending_tags.size() - 1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sends one beat, with an optional idle burst first. Valid stays high from
  // one beat to the next unless a gap is inserted.
  task automatic send_beat(logic [7:0] b, logic nr);
    htok_in_t beat;
    beat.data_in     = b;
    beat.new_request = nr;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tag_request_byte(b, nr);
    beats_sent++;
  endtask

  // Sends the assembled request; its first byte restarts the parser.
  task automatic send_queued();
    for (int i = 0; i < req_bytes.size(); i++) begin
      send_beat(req_bytes[i], i == 0);
    end
    req_bytes.delete();
  endtask

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      req_bytes.push_back(s[i]);
    end
  endfunction

  function automatic void put_crlf();
    req_bytes.push_back(CH_CR);
    req_bytes.push_back(CH_LF);
  endfunction

  // Mostly printable, now and then any byte value at all.
  function automatic logic [7:0] any_char();
    if ($urandom_range(0, 6) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return 8'($urandom_range(33, 126));
  endfunction

  // A token of random length. With delimiters allowed it also carries the
  // occasional space, colon or lone CR.
  function automatic void put_word(int maxlen, bit delims);
    repeat ($urandom_range(0, maxlen)) begin
      if (delims && $urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0:       req_bytes.push_back(CH_SPACE);
          1:       req_bytes.push_back(CH_COLON);
          default: req_bytes.push_back(CH_CR);
        endcase
      end else begin
        req_bytes.push_back(any_char());
      end
    end
  endfunction

  // Mostly well-formed requests with random content; some end early, some
  // carry bytes after the blank line, some are cut short by the next request.
  task automatic send_random_request();
    int k;
    k = $urandom_range(0, 3);
    case ($urandom_range(0, 6))
      0, 1, 2: put_text(verb_text[k]);
      3: begin
        put_text(verb_text[k]);
        put_word(4, 1'b0);
      end
      4: put_word(8, 1'b0);
      default: put_text(verb_text[k].substr(0, $urandom_range(0, 1)));
    endcase
    if ($urandom_range(0, 9) != 0) begin
      req_bytes.push_back(CH_SPACE);
      put_word(6, 1'b0);
      if ($urandom_range(0, 9) != 0) begin
        req_bytes.push_back(CH_SPACE);
        put_text("HTTP/1.");
        req_bytes.push_back(any_char());
        if ($urandom_range(0, 5) == 0) begin
          req_bytes.push_back(CH_SPACE);
          put_word(4, 1'b1);
        end
      end
    end
    put_crlf();
    repeat ($urandom_range(0, 3)) begin
      put_word(6, 1'b0);
      req_bytes.push_back(CH_COLON);
      case ($urandom_range(0, 5))
        0:       req_bytes.push_back(CH_CR);
        1:       req_bytes.push_back(any_char());
        default: req_bytes.push_back(CH_SPACE);
      endcase
      put_word(8, 1'b1);
      put_crlf();
    end
    put_crlf();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) req_bytes.push_back(any_char());
    end
    if ($urandom_range(0, 7) == 0) begin
      k = $urandom_range(1, req_bytes.size());
      while (req_bytes.size() > k) void'(req_bytes.pop_back());
    end
    send_queued();
  endtask

  // Short bursts of delimiters and raw bytes with random restarts.
  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 4))
        0:       b = CH_CR;
        1:       b = CH_LF;
        2:       b = CH_COLON;
        3:       b = CH_SPACE;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_beat(b, $urandom_range(0, 3) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Request line closed in the method part, a header whose name holds a space,
  // a CR dropped after the colon, a colon inside the value, a non-empty name
  // ending the request, and a byte after the request is done.
  task automatic test_header_lines();
    put_text("HEAD");
    put_crlf();
    put_text("k :");
    req_bytes.push_back(CH_CR);
    put_text("v:");
    put_crlf();
    req_bytes.push_back(8'hff);
    put_crlf();
    req_bytes.push_back(8'h00);
    send_queued();
  endtask

  // A held CR thrown away by a restart, a held CR turned into method data,
  // three spaces pushing the line into its ignored part, and a line end there.
  task automatic test_held_carriage_return();
    put_text("P ");
    req_bytes.push_back(CH_CR);
    send_queued();
    put_text("G");
    req_bytes.push_back(CH_CR);
    put_text("   x");
    put_crlf();
    send_queued();
  endtask

  // The receiver holds off long enough for the result queue to fill while the
  // sender keeps offering bytes, so the input has to stall.
  task automatic test_full_queue_stall();
    gaps_on       = 1'b0;
    receiver_hold = 80;
    put_text("PUT /a HTTP/1.0");
    put_crlf();
    put_text("h: x");
    put_crlf();
    put_crlf();
    send_queued();
    gaps_on = 1'b1;
  endtask

  // Random traffic; the last stretch runs with no idling on either side.
  task automatic test_random_traffic();
    int start;
    start = beats_sent;
    while (beats_sent - start < 270) begin
      if ($urandom_range(0, 7) == 0) begin
        send_noise();
      end else begin
        send_random_request();
      end
    end
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (beats_sent - start < 345) send_random_request();
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver back-pressure
  // ---------------------------------------------------------------------------

  function automatic bit field_ok(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Samples right after each rising edge, so it sees the values that the
  // block saw at that edge, then picks the ready level for the next cycle.
  initial begin : result_checker
    htok_out_t want;
    bit        ok;
    int        stall_left;
    logic      ready_next;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_tags.size() == 0) begin
          $display("%0t ns: unexpected beat, expected none, actual data 0x%0h kind %0d",
                   $time, out_data.data_out, out_data.token_kind);
          mismatches++;
        end else begin
          want = pending_tags.pop_front();
          ok = field_ok("data_out", want.data_out, out_data.data_out);
          ok = field_ok("token_kind", want.token_kind, out_data.token_kind) & ok;
          ok = field_ok("token_end", want.token_end, out_data.token_end) & ok;
          ok = field_ok("line_end", want.line_end, out_data.line_end) & ok;
          ok = field_ok("request_done", want.request_done, out_data.request_done) & ok;
          ok = field_ok("method_code", want.method_code, out_data.method_code) & ok;
          ok = field_ok("last", want.last, out_data.last) & ok;
          if (!ok) begin
            mismatches++;
          end
        end
      end
      if (receiver_hold > 0) begin
        receiver_hold--;
        ready_next = 1'b0;
      end else if (!stalls_on) begin
        ready_next = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_ready <= ready_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin : run
    int waited;
    parser_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_header_lines();
    test_held_carriage_return();
    test_full_queue_stall();
    test_random_traffic();
    in_valid <= 1'b0;

    // Drain: every tag still owed has to come out within the limit.
    waited = 0;
    while (pending_tags.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_tags.size() != 0) begin
      $display("%0t ns: %0d expected beats never arrived", $time, pending_tags.size());
      $display("http_request_tokenizer_top verification failed");
      $finish;
    end else begin
      // Wait on to catch any beat the block sends beyond the last one owed.
      repeat (20) @(posedge clk);
      if (mismatches == 0) begin
        $display("http_request_tokenizer_top verification clean");
      end else begin
        $display("http_request_tokenizer_top verification failed");
      end
      $finish;
    end
  end

endmodule
